[rtl/core/tpm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpm_pkg: shared types and constants for the plane mirror core
// Field widths, vertex and command structs, CSR codes, sequencer states and
// saturation helpers.
// ----------------------------------------------------------------------------
package tpm_pkg;

   localparam int POS_W      = 32;
   localparam int NRM_W      = 16;
   localparam int TEX_W      = 16;
   localparam int OFS_W      = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CMD_DEPTH  = 2;
   localparam int TRI_SIZE   = 3;

   // datapath widths
   localparam int PROD_P_W  = 48;   // pos * normal
   localparam int PROD_V_W  = 32;   // vnorm * normal
   localparam int D30_W     = 50;   // dot(p,n) - w*2^14
   localparam int DBL_D_W   = 37;   // 2 * round(d30 / 2^14)
   localparam int E_W       = 34;   // dot(v,n)
   localparam int DBL_E_W   = 35;
   localparam int PROD2P_W  = 53;
   localparam int PROD2V_W  = 51;
   localparam int MP_W      = 40;
   localparam int MN_W      = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_NX     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_NY     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_NZ     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_OFFSET = 2'd3;

   localparam logic signed [NRM_W-1:0] PLANE_NX_RESET     = 16'sd16384;
   localparam logic signed [NRM_W-1:0] PLANE_NY_RESET     = 16'sd0;
   localparam logic signed [NRM_W-1:0] PLANE_NZ_RESET     = 16'sd0;
   localparam logic signed [OFS_W-1:0] PLANE_OFFSET_RESET = 32'sd0;

   localparam logic [1:0] EMIT_ORIG  = 2'd0;
   localparam logic [1:0] EMIT_HELD0 = 2'd1;
   localparam logic [1:0] EMIT_CUR   = 2'd2;
   localparam logic [1:0] EMIT_HELD1 = 2'd3;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic signed [NRM_W-1:0] norm_x;
      logic signed [NRM_W-1:0] norm_y;
      logic signed [NRM_W-1:0] norm_z;
      logic signed [TEX_W-1:0] tex_u;
      logic signed [TEX_W-1:0] tex_v;
   } vertex_type;

   typedef struct packed {
      vertex_type vtx;
      logic       complete;
      logic       slot;
   } cmd_type;

   typedef struct packed {
      logic signed [NRM_W-1:0] nx;
      logic signed [NRM_W-1:0] ny;
      logic signed [NRM_W-1:0] nz;
      logic signed [OFS_W-1:0] offset;
   } plane_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_SUM,
      ST_MUL2,
      ST_FIN,
      ST_EMIT
   } back_state_type;

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [MP_W-1:0] x);
      logic signed [MP_W-1:0] hi;
      logic signed [MP_W-1:0] lo;
      hi = MP_W'({1'b0, {(POS_W-1){1'b1}}});
      lo = -hi - MP_W'(1);
      if (x > hi) begin
         sat_pos = hi[POS_W-1:0];
      end else if (x < lo) begin
         sat_pos = lo[POS_W-1:0];
      end else begin
         sat_pos = x[POS_W-1:0];
      end
   endfunction

   function automatic logic signed [NRM_W-1:0] sat_nrm(input logic signed [MN_W-1:0] x);
      logic signed [MN_W-1:0] hi;
      logic signed [MN_W-1:0] lo;
      hi = MN_W'({1'b0, {(NRM_W-1){1'b1}}});
      lo = -hi - MN_W'(1);
      if (x > hi) begin
         sat_nrm = hi[NRM_W-1:0];
      end else if (x < lo) begin
         sat_nrm = lo[NRM_W-1:0];
      end else begin
         sat_nrm = x[NRM_W-1:0];
      end
   endfunction

endpackage

[rtl/core/tpm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpm_front: vertex intake and triangle tagging
// Accepts vertices, marks the one that completes a triangle and the held
// slot, and queues them for the back end.
// ----------------------------------------------------------------------------
module tpm_front #(
   parameter int CMD_DEPTH = tpm_pkg::CMD_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  tpm_pkg::vertex_type req_vtx,
   output logic                cmd_valid,
   input  logic                cmd_pop,
   output tpm_pkg::cmd_type    cmd
);

   localparam int PTR_W = $clog2(CMD_DEPTH);
   localparam int CNT_W = $clog2(CMD_DEPTH + 1);

   tpm_pkg::cmd_type  q_ff [CMD_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [1:0]        tri_cnt_ff, tri_cnt_in;
   logic              accept;
   logic              deq;
   logic              complete;

   assign full      = (fill_ff == CNT_W'(CMD_DEPTH));
   assign cmd_valid = (fill_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign accept    = push & ~full;
   assign deq       = cmd_pop & cmd_valid;
   assign complete  = (tri_cnt_ff >= 2'(tpm_pkg::TRI_SIZE - 1));

   always_comb begin
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      fill_in    = fill_ff;
      tri_cnt_in = tri_cnt_ff;
      if (accept) begin
         wr_ptr_in  = (wr_ptr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         tri_cnt_in = complete ? 2'd0 : tri_cnt_ff + 2'd1;
      end
      if (deq) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (accept && !deq) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (!accept && deq) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         fill_ff    <= '0;
         tri_cnt_ff <= '0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         fill_ff    <= fill_in;
         tri_cnt_ff <= tri_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= '{vtx: req_vtx, complete: complete, slot: tri_cnt_ff[0]};
      end
   end

endmodule

[rtl/core/tpm_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpm_back: reflection sequencer and result stage
// Computes the mirrored vertex over several steps, holds the first two
// mirrored vertices of a triangle and emits results through an output
// register.
// ----------------------------------------------------------------------------
module tpm_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   output logic                cmd_pop,
   input  tpm_pkg::cmd_type    cmd,
   input  tpm_pkg::plane_type  plane,
   output logic                empty,
   input  logic                pop,
   output tpm_pkg::vertex_type rsp_vtx,
   output logic                rsp_mirrored,
   output logic                rsp_last
);

   localparam logic signed [tpm_pkg::D30_W-1:0]    HALF_D  = tpm_pkg::D30_W'(1) << 13;
   localparam logic signed [tpm_pkg::PROD2P_W-1:0] HALF_P  = tpm_pkg::PROD2P_W'(1) << 13;
   localparam logic signed [tpm_pkg::PROD2V_W-1:0] HALF_V  = tpm_pkg::PROD2V_W'(1) << 27;

   tpm_pkg::back_state_type state_ff, state_in;
   tpm_pkg::cmd_type        cur_ff, cur_in;
   tpm_pkg::vertex_type     mir_ff, mir_in;
   tpm_pkg::vertex_type     held_ff [2];
   logic                    held_we;
   logic [1:0]              emit_idx_ff, emit_idx_in;

   logic signed [tpm_pkg::PROD_P_W-1:0] prod_p_ff [3], prod_p_in [3];
   logic signed [tpm_pkg::PROD_V_W-1:0] prod_v_ff [3], prod_v_in [3];
   logic signed [tpm_pkg::DBL_D_W-1:0]  dbl_d_ff, dbl_d_in;
   logic signed [tpm_pkg::DBL_E_W-1:0]  dbl_e_ff, dbl_e_in;
   logic signed [tpm_pkg::PROD2P_W-1:0] prod2p_ff [3], prod2p_in [3];
   logic signed [tpm_pkg::PROD2V_W-1:0] prod2v_ff [3], prod2v_in [3];

   logic signed [tpm_pkg::POS_W-1:0] p_arr [3];
   logic signed [tpm_pkg::NRM_W-1:0] v_arr [3];
   logic signed [tpm_pkg::NRM_W-1:0] n_arr [3];
   logic signed [tpm_pkg::POS_W-1:0] mp [3];
   logic signed [tpm_pkg::NRM_W-1:0] mn [3];
   logic signed [tpm_pkg::D30_W-1:0] d30;
   logic signed [tpm_pkg::D30_W-1:0] d30r;
   logic signed [tpm_pkg::E_W-1:0]   e_sum;
   logic signed [tpm_pkg::PROD2P_W-1:0] shp;
   logic signed [tpm_pkg::PROD2V_W-1:0] shv;

   logic                rsp_valid_ff, rsp_valid_in;
   tpm_pkg::vertex_type rsp_vtx_ff, res_vtx;
   logic                rsp_mir_ff, res_mir;
   logic                rsp_last_ff, res_last;
   logic                out_load;

   assign p_arr[0] = cur_ff.vtx.pos_x;
   assign p_arr[1] = cur_ff.vtx.pos_y;
   assign p_arr[2] = cur_ff.vtx.pos_z;
   assign v_arr[0] = cur_ff.vtx.norm_x;
   assign v_arr[1] = cur_ff.vtx.norm_y;
   assign v_arr[2] = cur_ff.vtx.norm_z;
   assign n_arr[0] = plane.nx;
   assign n_arr[1] = plane.ny;
   assign n_arr[2] = plane.nz;

   assign empty        = ~rsp_valid_ff;
   assign rsp_vtx      = rsp_vtx_ff;
   assign rsp_mirrored = rsp_mir_ff;
   assign rsp_last     = rsp_last_ff;
   assign out_load     = ~rsp_valid_ff | pop;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tpm_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               state_in = tpm_pkg::ST_MUL1;
            end
         end
         tpm_pkg::ST_MUL1: state_in = tpm_pkg::ST_SUM;
         tpm_pkg::ST_SUM:  state_in = tpm_pkg::ST_MUL2;
         tpm_pkg::ST_MUL2: state_in = tpm_pkg::ST_FIN;
         tpm_pkg::ST_FIN:  state_in = tpm_pkg::ST_EMIT;
         tpm_pkg::ST_EMIT: begin
            if (out_load && res_last) begin
               state_in = tpm_pkg::ST_IDLE;
            end
         end
         default: state_in = tpm_pkg::ST_IDLE;
      endcase
   end

   // result select
   always_comb begin
      case (emit_idx_ff)
         tpm_pkg::EMIT_ORIG: begin
            res_vtx  = cur_ff.vtx;
            res_mir  = 1'b0;
            res_last = ~cur_ff.complete;
         end
         tpm_pkg::EMIT_HELD0: begin
            res_vtx  = held_ff[0];
            res_mir  = 1'b1;
            res_last = 1'b0;
         end
         tpm_pkg::EMIT_CUR: begin
            res_vtx  = mir_ff;
            res_mir  = 1'b1;
            res_last = 1'b0;
         end
         tpm_pkg::EMIT_HELD1: begin
            res_vtx  = held_ff[1];
            res_mir  = 1'b1;
            res_last = 1'b1;
         end
         default: begin
            res_vtx  = cur_ff.vtx;
            res_mir  = 1'b0;
            res_last = 1'b1;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd_pop      = 1'b0;
      cur_in       = cur_ff;
      mir_in       = mir_ff;
      held_we      = 1'b0;
      emit_idx_in  = emit_idx_ff;
      dbl_d_in     = dbl_d_ff;
      dbl_e_in     = dbl_e_ff;
      rsp_valid_in = rsp_valid_ff & ~pop;
      d30   = tpm_pkg::D30_W'(prod_p_ff[0]) + tpm_pkg::D30_W'(prod_p_ff[1])
            + tpm_pkg::D30_W'(prod_p_ff[2])
            - (tpm_pkg::D30_W'(plane.offset) <<< 14);
      d30r  = d30 + HALF_D;
      e_sum = tpm_pkg::E_W'(prod_v_ff[0]) + tpm_pkg::E_W'(prod_v_ff[1])
            + tpm_pkg::E_W'(prod_v_ff[2]);
      shp   = '0;
      shv   = '0;
      for (int i = 0; i < 3; i++) begin
         prod_p_in[i] = prod_p_ff[i];
         prod_v_in[i] = prod_v_ff[i];
         prod2p_in[i] = prod2p_ff[i];
         prod2v_in[i] = prod2v_ff[i];
         shp   = (prod2p_ff[i] + HALF_P) >>> 14;
         shv   = (prod2v_ff[i] + HALF_V) >>> 28;
         mp[i] = tpm_pkg::sat_pos(tpm_pkg::MP_W'(p_arr[i]) - tpm_pkg::MP_W'(shp));
         mn[i] = tpm_pkg::sat_nrm(tpm_pkg::MN_W'(v_arr[i]) - tpm_pkg::MN_W'(shv));
      end
      case (state_ff)
         tpm_pkg::ST_IDLE: begin
            cmd_pop     = cmd_valid;
            cur_in      = cmd;
            emit_idx_in = tpm_pkg::EMIT_ORIG;
         end
         tpm_pkg::ST_MUL1: begin
            for (int i = 0; i < 3; i++) begin
               prod_p_in[i] = tpm_pkg::PROD_P_W'(p_arr[i]) * tpm_pkg::PROD_P_W'(n_arr[i]);
               prod_v_in[i] = tpm_pkg::PROD_V_W'(v_arr[i]) * tpm_pkg::PROD_V_W'(n_arr[i]);
            end
         end
         tpm_pkg::ST_SUM: begin
            dbl_d_in = tpm_pkg::DBL_D_W'(d30r >>> 14) <<< 1;
            dbl_e_in = tpm_pkg::DBL_E_W'(e_sum) <<< 1;
         end
         tpm_pkg::ST_MUL2: begin
            for (int i = 0; i < 3; i++) begin
               prod2p_in[i] = tpm_pkg::PROD2P_W'(dbl_d_ff) * tpm_pkg::PROD2P_W'(n_arr[i]);
               prod2v_in[i] = tpm_pkg::PROD2V_W'(dbl_e_ff) * tpm_pkg::PROD2V_W'(n_arr[i]);
            end
         end
         tpm_pkg::ST_FIN: begin
            mir_in.pos_x  = mp[0];
            mir_in.pos_y  = mp[1];
            mir_in.pos_z  = mp[2];
            mir_in.norm_x = mn[0];
            mir_in.norm_y = mn[1];
            mir_in.norm_z = mn[2];
            mir_in.tex_u  = cur_ff.vtx.tex_u;
            mir_in.tex_v  = cur_ff.vtx.tex_v;
            held_we       = ~cur_ff.complete;
         end
         tpm_pkg::ST_EMIT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               emit_idx_in  = emit_idx_ff + 2'd1;
            end
         end
         default: begin
            cmd_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         emit_idx_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         emit_idx_ff  <= emit_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      mir_ff   <= mir_in;
      dbl_d_ff <= dbl_d_in;
      dbl_e_ff <= dbl_e_in;
      for (int i = 0; i < 3; i++) begin
         prod_p_ff[i] <= prod_p_in[i];
         prod_v_ff[i] <= prod_v_in[i];
         prod2p_ff[i] <= prod2p_in[i];
         prod2v_ff[i] <= prod2v_in[i];
      end
      if (held_we) begin
         held_ff[cur_ff.slot] <= mir_in;
      end
      if (state_ff == tpm_pkg::ST_EMIT && out_load) begin
         rsp_vtx_ff  <= res_vtx;
         rsp_mir_ff  <= res_mir;
         rsp_last_ff <= res_last;
      end
   end

endmodule

[rtl/core/triangle_plane_mirror_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_plane_mirror_core: vertex reflection across a plane
// Passes each vertex through and emits the mirrored triangle, in reversed
// winding, after every third vertex.
//
//   channel  handshake     payload
//   req      push / full   pos xyz, norm xyz, tex uv
//   rsp      pop / empty   pos xyz, norm xyz, tex uv, mirrored, last
//   csr      csr_wr_en     csr_index, csr_wdata
//
// The back-end sequencer handles one item at a time: load, multiply, sum,
// multiply, round/saturate, then one result per cycle unless pop stalls:
// one result, or four for the item that completes a triangle.
// The intake queue holds CMD_DEPTH items, so push is taken while the back
// end works. A stalled pop holds the output register and stalls the sequencer.
// Reset is synchronous: it clears control state, loads the plane defaults, not datapath.
// ----------------------------------------------------------------------------
module triangle_plane_mirror_core #(
   parameter int CMD_DEPTH = tpm_pkg::CMD_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic signed [tpm_pkg::POS_W-1:0]    req_pos_x,
   input  logic signed [tpm_pkg::POS_W-1:0]    req_pos_y,
   input  logic signed [tpm_pkg::POS_W-1:0]    req_pos_z,
   input  logic signed [tpm_pkg::NRM_W-1:0]    req_norm_x,
   input  logic signed [tpm_pkg::NRM_W-1:0]    req_norm_y,
   input  logic signed [tpm_pkg::NRM_W-1:0]    req_norm_z,
   input  logic signed [tpm_pkg::TEX_W-1:0]    req_tex_u,
   input  logic signed [tpm_pkg::TEX_W-1:0]    req_tex_v,
   output logic                                empty,
   input  logic                                pop,
   output logic signed [tpm_pkg::POS_W-1:0]    rsp_pos_x,
   output logic signed [tpm_pkg::POS_W-1:0]    rsp_pos_y,
   output logic signed [tpm_pkg::POS_W-1:0]    rsp_pos_z,
   output logic signed [tpm_pkg::NRM_W-1:0]    rsp_norm_x,
   output logic signed [tpm_pkg::NRM_W-1:0]    rsp_norm_y,
   output logic signed [tpm_pkg::NRM_W-1:0]    rsp_norm_z,
   output logic signed [tpm_pkg::TEX_W-1:0]    rsp_tex_u,
   output logic signed [tpm_pkg::TEX_W-1:0]    rsp_tex_v,
   output logic                                rsp_mirrored,
   output logic                                rsp_last,
   input  logic                                csr_wr_en,
   input  logic [tpm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tpm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   tpm_pkg::plane_type  plane_ff, plane_in;
   tpm_pkg::vertex_type req_vtx;
   tpm_pkg::vertex_type rsp_vtx;
   tpm_pkg::cmd_type    cmd;
   logic                cmd_valid;
   logic                cmd_pop;

   assign req_vtx = '{pos_x: req_pos_x, pos_y: req_pos_y, pos_z: req_pos_z,
                      norm_x: req_norm_x, norm_y: req_norm_y, norm_z: req_norm_z,
                      tex_u: req_tex_u, tex_v: req_tex_v};

   assign rsp_pos_x  = rsp_vtx.pos_x;
   assign rsp_pos_y  = rsp_vtx.pos_y;
   assign rsp_pos_z  = rsp_vtx.pos_z;
   assign rsp_norm_x = rsp_vtx.norm_x;
   assign rsp_norm_y = rsp_vtx.norm_y;
   assign rsp_norm_z = rsp_vtx.norm_z;
   assign rsp_tex_u  = rsp_vtx.tex_u;
   assign rsp_tex_v  = rsp_vtx.tex_v;

   always_comb begin
      plane_in = plane_ff;
      if (csr_wr_en) begin
         case (csr_index)
            tpm_pkg::CSR_PLANE_NX:     plane_in.nx     = csr_wdata[tpm_pkg::NRM_W-1:0];
            tpm_pkg::CSR_PLANE_NY:     plane_in.ny     = csr_wdata[tpm_pkg::NRM_W-1:0];
            tpm_pkg::CSR_PLANE_NZ:     plane_in.nz     = csr_wdata[tpm_pkg::NRM_W-1:0];
            tpm_pkg::CSR_PLANE_OFFSET: plane_in.offset = csr_wdata[tpm_pkg::OFS_W-1:0];
            default:                   plane_in        = plane_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff.nx     <= tpm_pkg::PLANE_NX_RESET;
         plane_ff.ny     <= tpm_pkg::PLANE_NY_RESET;
         plane_ff.nz     <= tpm_pkg::PLANE_NZ_RESET;
         plane_ff.offset <= tpm_pkg::PLANE_OFFSET_RESET;
      end else begin
         plane_ff <= plane_in;
      end
   end

   tpm_front #(
      .CMD_DEPTH (CMD_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_vtx   (req_vtx),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd)
   );

   tpm_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (cmd_valid),
      .cmd_pop      (cmd_pop),
      .cmd          (cmd),
      .plane        (plane_ff),
      .empty        (empty),
      .pop          (pop),
      .rsp_vtx      (rsp_vtx),
      .rsp_mirrored (rsp_mirrored),
      .rsp_last     (rsp_last)
   );

endmodule
